[src/btqi_pkg.sv]
// shared constants and types of the button and trigger input qualifier
package btqi_pkg;

    localparam int BUTTON_COUNT  = 4;
    localparam int TRIGGER_COUNT = 2;
    localparam int SUPPLY_COUNT  = 4;
    localparam int DELAY_W       = 8;
    localparam int FAULT_W       = 16;
    localparam int CFG_INDEX_W   = 4;
    localparam int CFG_DATA_W    = 16;

    localparam logic [FAULT_W-1:0]      FAULT_MAX         = {FAULT_W{1'b1}};
    localparam logic [DELAY_W-1:0]      DEBOUNCE_RESET    = 8'd10;
    localparam logic [FAULT_W-1:0]      FAULT_LIMIT_RESET = 16'd1000;
    localparam logic [SUPPLY_COUNT-1:0] SUPPLY_RESET      = 4'b0011;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_DELAY = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAULT_LIMIT    = 4'd1;

    typedef enum logic [1:0] {
        SUP_FOLLOW    = 2'd0,
        SUP_FORCE_ON  = 2'd1,
        SUP_FORCE_OFF = 2'd2,
        SUP_HOLD      = 2'd3
    } supply_mode_t;

    typedef struct packed {
        logic pressed;
        logic error;
    } trigger_status_t;

    typedef struct packed {
        logic [BUTTON_COUNT-1:0]  buttons_pressed;
        logic [TRIGGER_COUNT-1:0] trigger_pressed;
        logic [TRIGGER_COUNT-1:0] trigger_error;
        logic [SUPPLY_COUNT-1:0]  supply_enable;
    } btqi_result_t;

endpackage

[src/btqi_if.sv]
// input and output channel interfaces
interface btqi_in_if;
    import btqi_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [BUTTON_COUNT-1:0]    button_pins;
    logic [2*TRIGGER_COUNT-1:0] trigger_pins;
    logic [SUPPLY_COUNT-1:0]    supply_request;
    logic [2*SUPPLY_COUNT-1:0]  supply_mode_sel;

    modport source (output valid, button_pins, trigger_pins, supply_request,
                    supply_mode_sel, input ready);
    modport sink (input valid, button_pins, trigger_pins, supply_request,
                  supply_mode_sel, output ready);
endinterface

interface btqi_out_if;
    import btqi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [BUTTON_COUNT-1:0]  buttons_pressed;
    logic [TRIGGER_COUNT-1:0] trigger_pressed;
    logic [TRIGGER_COUNT-1:0] trigger_error;
    logic [SUPPLY_COUNT-1:0]  supply_enable;

    modport source (output valid, buttons_pressed, trigger_pressed, trigger_error,
                    supply_enable, input ready);
    modport sink (input valid, buttons_pressed, trigger_pressed, trigger_error,
                  supply_enable, output ready);
endinterface

[src/btqi_button_lane.sv]
// debounce counter lane for one button pin
module btqi_button_lane (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        pin,
    input  logic [btqi_pkg::DELAY_W-1:0] delay,
    output logic                        level
);
    import btqi_pkg::*;

    logic               level_reg;
    logic               level_next;
    logic [DELAY_W-1:0] count_reg;
    logic [DELAY_W-1:0] count_next;
    logic [DELAY_W-1:0] count_inc;

    always_comb
    begin
        // pins are active low: equal means disagreement
        count_inc  = (level_reg == pin) ? count_reg + DELAY_W'(1) : '0;
        level_next = level_reg;
        count_next = count_inc;
        if (count_inc >= delay)
        begin
            level_next = ~pin;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            level_reg <= level_next;
            count_reg <= count_next;
        end
    end

    assign level = level_next;

endmodule

[src/btqi_trigger_lane.sv]
// contact pair check and fault counter lane for one trigger
module btqi_trigger_lane (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        contact_a,
    input  logic                        contact_b,
    input  logic [btqi_pkg::FAULT_W-1:0] limit,
    output btqi_pkg::trigger_status_t    status
);
    import btqi_pkg::*;

    logic               pressed_reg;
    logic               pressed_next;
    logic               error_reg;
    logic               error_next;
    logic [FAULT_W-1:0] fault_reg;
    logic [FAULT_W-1:0] fault_next;

    always_comb
    begin
        pressed_next = pressed_reg;
        fault_next   = fault_reg;
        if (contact_a && !contact_b)
        begin
            pressed_next = 1'b0;
            fault_next   = '0;
        end
        else if (!contact_a && contact_b)
        begin
            pressed_next = 1'b1;
            fault_next   = '0;
        end
        else if (fault_reg != FAULT_MAX)
        begin
            fault_next = fault_reg + FAULT_W'(1);
        end

        error_next = error_reg;
        if (fault_next > limit)
            error_next = 1'b1;
        if (fault_next == '0)
            error_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= 1'b0;
            error_reg   <= 1'b0;
            fault_reg   <= '0;
        end
        else if (advance)
        begin
            pressed_reg <= pressed_next;
            error_reg   <= error_next;
            fault_reg   <= fault_next;
        end
    end

    assign status.pressed = pressed_next;
    assign status.error   = error_next;

endmodule

[src/btqi_supply_lane.sv]
// override control lane for one supply output
module btqi_supply_lane (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   reset_level,
    input  logic                   request,
    input  btqi_pkg::supply_mode_t mode,
    output logic                   level
);
    import btqi_pkg::*;

    logic level_reg;
    logic level_next;

    always_comb
    begin
        case (mode)
            SUP_FOLLOW:    level_next = request;
            SUP_FORCE_ON:  level_next = 1'b1;
            SUP_FORCE_OFF: level_next = 1'b0;
            SUP_HOLD:      level_next = level_reg;
            default:       level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= reset_level;
        else if (advance)
            level_reg <= level_next;
    end

    assign level = level_next;

endmodule

[src/btqi_merge.sv]
// merges lane results into the output register with a skid stage
module btqi_merge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  btqi_pkg::btqi_result_t res,
    output logic                   ready,
    btqi_out_if.source             out_ch
);
    import btqi_pkg::*;

    logic         out_valid_reg;
    logic         out_valid_next;
    btqi_result_t out_data_reg;
    btqi_result_t out_data_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    btqi_result_t skid_data_reg;
    btqi_result_t skid_data_next;
    logic         pop;

    assign pop = out_valid_reg && out_ch.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign ready                  = !skid_valid_reg;
    assign out_ch.valid           = out_valid_reg;
    assign out_ch.buttons_pressed = out_data_reg.buttons_pressed;
    assign out_ch.trigger_pressed = out_data_reg.trigger_pressed;
    assign out_ch.trigger_error   = out_data_reg.trigger_error;
    assign out_ch.supply_enable   = out_data_reg.supply_enable;

endmodule

[src/button_trigger_input_qualifier_core.sv]
// top level of the button and trigger input qualifier
//
// channel  dir  payload                                                    
// in_ch    in   button_pins, trigger_pins, supply_request, supply_mode_sel
// out_ch   out  buttons_pressed, trigger_pressed, trigger_error, supply_enable
// cfg      in   cfg_wr_en, cfg_index, cfg_data (0 debounce delay, 1 fault limit)
//
// one item per cycle while in_ch.ready is high; each result is registered
// every lane updates its state in the transfer cycle, so items follow back to back
// a skid stage behind the output register absorbs one result while out_ch stalls
// in_ch.ready drops only while both the output register and the skid stage are full
// reset clears button/trigger lanes, sets supply/cfg defaults; no clearing pass
module button_trigger_input_qualifier_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [btqi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [btqi_pkg::CFG_DATA_W-1:0]  cfg_data,
    btqi_in_if.sink                         in_ch,
    btqi_out_if.source                      out_ch
);
    import btqi_pkg::*;

    logic [DELAY_W-1:0] debounce_delay_reg;
    logic [FAULT_W-1:0] fault_limit_reg;
    logic               advance;
    logic               merge_ready;
    btqi_result_t       res;
    trigger_status_t    trig_status [TRIGGER_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_delay_reg <= DEBOUNCE_RESET;
            fault_limit_reg    <= FAULT_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_DEBOUNCE_DELAY)
                debounce_delay_reg <= cfg_data[DELAY_W-1:0];
            else if (cfg_index == CFG_FAULT_LIMIT)
                fault_limit_reg <= cfg_data[FAULT_W-1:0];
        end
    end

    assign in_ch.ready = merge_ready;
    assign advance     = in_ch.valid && merge_ready;

    for (genvar i = 0; i < BUTTON_COUNT; i++)
    begin : g_button
        btqi_button_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .pin     (in_ch.button_pins[i]),
            .delay   (debounce_delay_reg),
            .level   (res.buttons_pressed[i])
        );
    end

    for (genvar i = 0; i < TRIGGER_COUNT; i++)
    begin : g_trigger
        btqi_trigger_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .contact_a (in_ch.trigger_pins[2*i]),
            .contact_b (in_ch.trigger_pins[2*i+1]),
            .limit     (fault_limit_reg),
            .status    (trig_status[i])
        );
        assign res.trigger_pressed[i] = trig_status[i].pressed;
        assign res.trigger_error[i]   = trig_status[i].error;
    end

    for (genvar i = 0; i < SUPPLY_COUNT; i++)
    begin : g_supply
        btqi_supply_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (advance),
            .reset_level (SUPPLY_RESET[i]),
            .request     (in_ch.supply_request[i]),
            .mode        (supply_mode_t'(in_ch.supply_mode_sel[2*i +: 2])),
            .level       (res.supply_enable[i])
        );
    end

    btqi_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (advance),
        .res    (res),
        .ready  (merge_ready),
        .out_ch (out_ch)
    );

endmodule

[src/btqi_checker.sv]
// port-level assertions for the qualifier core and their bind
module btqi_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // input backpressure only with a result waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

    // each input transfer yields a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result after input transfer");

    // a full skid stage holds input off until the output moves
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && !out_ready |=> !in_ready)
        else $error("input ready with full buffers and stalled output");

endmodule

bind button_trigger_input_qualifier_core btqi_checker u_btqi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
);
